// ===== hw/rtl/qbs_pkg.sv =====
package qbs_pkg;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  tile_index;
    logic [47:0] local_time;
    logic [2:0]  target_index;
    logic        status_bit;
  } req_t;

  typedef struct packed {
    logic [1:0]  message_kind;
    logic [3:0]  destination;
    logic [47:0] barrier_time;
    logic        last;
  } rsp_t;

  localparam logic [2:0] KIND_WAIT   = 3'd0;
  localparam logic [2:0] KIND_ARRIVE = 3'd1;
  localparam logic [2:0] KIND_ACK    = 3'd2;
  localparam logic [2:0] KIND_TARGET = 3'd3;
  localparam logic [2:0] KIND_THREAD = 3'd4;

  localparam logic [1:0] MSG_RELEASE = 2'd0;
  localparam logic [1:0] MSG_ARRIVAL = 2'd1;
  localparam logic [1:0] MSG_ACK     = 2'd2;
  localparam logic [1:0] MSG_NOTIFY  = 2'd3;

  localparam logic [1:0] DEST_TILE = 2'd0;
  localparam logic [1:0] DEST_IDX  = 2'd1;
  localparam logic [1:0] DEST_ZERO = 2'd2;

  localparam logic [1:0] REG_QUANTUM = 2'd0;
  localparam logic [1:0] REG_TILES   = 2'd1;
  localparam logic [1:0] REG_TARGETS = 2'd2;

  typedef struct packed {
    logic       load_in;
    logic       store_wait;
    logic       store_target;
    logic       store_thread;
    logic       inc_count;
    logic       clear_count;
    logic       scan_start;
    logic       scan_step;
    logic       br_eval;
    logic       min_eval;
    logic       run_eval;
    logic       rel_clear;
    logic       nb_add;
    logic       div_start;
    logic       nb_div;
    logic       push;
    logic [1:0] push_kind;
    logic [1:0] push_dest;
    logic       flush;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       early;
    logic       br_hit;
    logic       ack_equal;
    logic       tgt_hit;
    logic       rel_hit;
    logic       direct;
    logic       div_done;
    logic       push_ok;
    logic       last_tile;
    logic       last_tgt;
    logic       tiles_zero;
    logic       tgts_zero;
  } sts_t;

endpackage

// ===== hw/rtl/qbs_datapath.sv =====
module qbs_datapath #(
  parameter int TILES     = 16,
  parameter int TARGETS   = 8,
  parameter int TIME_BITS = 48
) (
  input  logic          clk,
  input  logic          rst,
  input  qbs_pkg::req_t req,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  input  qbs_pkg::cmd_t cmd,
  output qbs_pkg::sts_t sts,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output qbs_pkg::rsp_t rsp
);

  localparam int TAW = (TILES > 1) ? $clog2(TILES) : 1;
  localparam int GAW = (TARGETS > 1) ? $clog2(TARGETS) : 1;
  localparam int MAXN = (TILES > TARGETS) ? TILES : TARGETS;
  localparam int IW = $clog2(MAXN + 1);
  localparam int RCW = $clog2(TARGETS + 1);
  localparam int DCW = $clog2(TIME_BITS + 1);

  logic [31:0]          quantum;
  logic [4:0]           tiles_cfg;
  logic [3:0]           tgts_cfg;
  logic [TIME_BITS-1:0] nb;
  logic [3:0]           count;
  logic [TILES-1:0]     waiting;
  logic [TILES-1:0]     thr_run;
  logic [TARGETS-1:0]   tgt_run;
  logic [TIME_BITS-1:0] clk_mem [TILES];
  logic [TILES-1:0]     clk_vld;
  logic [TIME_BITS-1:0] rd_clock;
  logic                 rd_vld;
  qbs_pkg::req_t        item;
  logic [IW-1:0]        idx;
  logic                 blocked;
  logic                 reached;
  logic                 any;
  logic [TIME_BITS-1:0] low;
  logic [RCW-1:0]       run_cnt;
  logic [31:0]          rem;
  logic [TIME_BITS-1:0] dq;
  logic [DCW-1:0]       dcnt;
  logic                 pend_v;
  logic [1:0]           pend_kind;
  logic [3:0]           pend_dest;
  logic [TIME_BITS-1:0] pend_time;

  logic [IW-1:0]        tiles_lim;
  logic [IW-1:0]        tgts_lim;
  logic [TAW-1:0]       ta;
  logic [GAW-1:0]       ga;
  logic [TIME_BITS-1:0] clock_val;
  logic [TIME_BITS-1:0] in_time;
  logic                 slot_free;
  logic [3:0]           push_dest;
  logic [32:0]          div_tmp;
  logic [TIME_BITS:0]   add_sum;
  logic [TIME_BITS:0]   div_sum;
  logic [TIME_BITS-1:0] add_sat;
  logic [TIME_BITS-1:0] div_sat;

  always_comb begin
    if (32'(tiles_cfg) < 32'(TILES)) begin
      tiles_lim = IW'(tiles_cfg);
    end else begin
      tiles_lim = IW'(TILES);
    end
    if (32'(tgts_cfg) < 32'(TARGETS)) begin
      tgts_lim = IW'(tgts_cfg);
    end else begin
      tgts_lim = IW'(TARGETS);
    end
  end

  assign ta = idx[TAW-1:0];
  assign ga = idx[GAW-1:0];
  assign clock_val = rd_vld ? rd_clock : '0;
  assign in_time = TIME_BITS'(item.local_time);
  assign slot_free = !rsp_valid || rsp_ready;

  always_comb begin
    case (cmd.push_dest)
      qbs_pkg::DEST_TILE: push_dest = item.tile_index;
      qbs_pkg::DEST_IDX:  push_dest = 4'(idx);
      default:            push_dest = 4'd0;
    endcase
  end

  assign div_tmp = {rem, dq[TIME_BITS-1]};
  assign add_sum = {1'b0, nb} + (TIME_BITS + 1)'(quantum);
  assign div_sum = {1'b0, low - TIME_BITS'(rem)} + (TIME_BITS + 1)'(quantum);
  assign add_sat = add_sum[TIME_BITS] ? '1 : add_sum[TIME_BITS-1:0];
  assign div_sat = div_sum[TIME_BITS] ? '1 : div_sum[TIME_BITS-1:0];

  always_comb begin
    sts.kind       = item.kind;
    sts.early      = in_time < nb;
    sts.br_hit     = reached && !blocked;
    sts.ack_equal  = 32'(count) == 32'(run_cnt);
    sts.tgt_hit    = tgt_run[ga];
    sts.rel_hit    = waiting[ta] && (clock_val < nb);
    sts.direct     = !any || (nb > low) || (quantum == 32'd0);
    sts.div_done   = dcnt == '0;
    sts.push_ok    = !pend_v || slot_free;
    sts.last_tile  = idx == (tiles_lim - IW'(1));
    sts.last_tgt   = idx == (tgts_lim - IW'(1));
    sts.tiles_zero = tiles_lim == '0;
    sts.tgts_zero  = tgts_lim == '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.store_wait && (32'(item.tile_index) < 32'(tiles_lim))) begin
      clk_mem[TAW'(item.tile_index)] <= in_time;
    end
    rd_clock <= clk_mem[ta];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      item <= req;
    end
    if (cmd.min_eval && waiting[ta] && (!any || clock_val < low)) begin
      low <= clock_val;
    end
    if (cmd.div_start) begin
      rem <= '0;
      dq <= low - nb;
    end else if (dcnt != '0) begin
      rem <= (div_tmp >= {1'b0, quantum}) ? 32'(div_tmp - {1'b0, quantum}) : 32'(div_tmp);
      dq <= {dq[TIME_BITS-2:0], 1'b0};
    end
    if (cmd.push) begin
      pend_kind <= cmd.push_kind;
      pend_dest <= push_dest;
      pend_time <= nb;
    end
    if ((cmd.push || cmd.flush) && pend_v) begin
      rsp.message_kind <= pend_kind;
      rsp.destination <= pend_dest;
      rsp.barrier_time <= 48'(pend_time);
      rsp.last <= cmd.flush;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= 32'd1000;
      tiles_cfg <= 5'd16;
      tgts_cfg <= 4'd8;
      nb <= TIME_BITS'(1000);
      count <= '0;
      waiting <= '0;
      thr_run <= '0;
      tgt_run <= '1;
      clk_vld <= '0;
      rd_vld <= 1'b0;
      idx <= '0;
      blocked <= 1'b0;
      reached <= 1'b0;
      any <= 1'b0;
      run_cnt <= '0;
      dcnt <= '0;
      pend_v <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      rd_vld <= clk_vld[ta];
      if (cmd.store_wait && (32'(item.tile_index) < 32'(tiles_lim))) begin
        clk_vld[TAW'(item.tile_index)] <= 1'b1;
        waiting[TAW'(item.tile_index)] <= 1'b1;
      end
      if (cmd.store_thread && (32'(item.tile_index) < 32'(TILES))) begin
        thr_run[TAW'(item.tile_index)] <= item.status_bit;
      end
      if (cmd.store_target && (32'(item.target_index) < 32'(tgts_lim))) begin
        tgt_run[GAW'(item.target_index)] <= item.status_bit;
      end
      if (cmd.inc_count) begin
        count <= count + 4'd1;
      end else if (cmd.clear_count) begin
        count <= '0;
      end
      if (cmd.scan_start) begin
        idx <= '0;
        blocked <= 1'b0;
        reached <= 1'b0;
        any <= 1'b0;
        run_cnt <= '0;
      end else if (cmd.scan_step) begin
        idx <= idx + IW'(1);
      end
      if (cmd.br_eval) begin
        if (clock_val < nb) begin
          if (thr_run[ta]) begin
            blocked <= 1'b1;
          end
        end else begin
          reached <= 1'b1;
        end
      end
      if (cmd.min_eval && waiting[ta]) begin
        any <= 1'b1;
      end
      if (cmd.run_eval && tgt_run[ga]) begin
        run_cnt <= run_cnt + RCW'(1);
      end
      if (cmd.rel_clear) begin
        waiting[ta] <= 1'b0;
      end
      if (cmd.div_start) begin
        dcnt <= DCW'(TIME_BITS);
      end else if (dcnt != '0) begin
        dcnt <= dcnt - DCW'(1);
      end
      if (cmd.nb_add) begin
        nb <= add_sat;
      end else if (cmd.nb_div) begin
        nb <= div_sat;
      end
      if (cmd.push) begin
        pend_v <= 1'b1;
      end else if (cmd.flush) begin
        pend_v <= 1'b0;
      end
      if ((cmd.push || cmd.flush) && pend_v) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          qbs_pkg::REG_QUANTUM: begin
            quantum <= cfg_data;
            nb <= TIME_BITS'(cfg_data);
          end
          qbs_pkg::REG_TILES:   tiles_cfg <= cfg_data[4:0];
          qbs_pkg::REG_TARGETS: tgts_cfg <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== hw/rtl/qbs_ctrl.sv =====
module qbs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  qbs_pkg::sts_t sts,
  output qbs_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_BR_RD    = 4'd2;
  localparam logic [3:0] S_BR_EV    = 4'd3;
  localparam logic [3:0] S_BR_END   = 4'd4;
  localparam logic [3:0] S_ACK_CNT  = 4'd5;
  localparam logic [3:0] S_ACK_CMP  = 4'd6;
  localparam logic [3:0] S_ACK_EMIT = 4'd7;
  localparam logic [3:0] S_MIN_RD   = 4'd8;
  localparam logic [3:0] S_MIN_EV   = 4'd9;
  localparam logic [3:0] S_CALC     = 4'd10;
  localparam logic [3:0] S_DIV      = 4'd11;
  localparam logic [3:0] S_REL_RD   = 4'd12;
  localparam logic [3:0] S_REL_EV   = 4'd13;
  localparam logic [3:0] S_NOTE     = 4'd14;
  localparam logic [3:0] S_FLUSH    = 4'd15;

  logic [3:0] state;
  logic [3:0] state_next;

  assign req_ready = state == S_IDLE;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_in = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.kind)
          qbs_pkg::KIND_WAIT: begin
            if (sts.early) begin
              cmd.push = 1'b1;
              cmd.push_kind = qbs_pkg::MSG_RELEASE;
              cmd.push_dest = qbs_pkg::DEST_TILE;
              state_next = S_FLUSH;
            end else begin
              cmd.store_wait = 1'b1;
              cmd.scan_start = 1'b1;
              state_next = sts.tiles_zero ? S_BR_END : S_BR_RD;
            end
          end
          qbs_pkg::KIND_ARRIVE: begin
            cmd.inc_count = 1'b1;
            cmd.scan_start = 1'b1;
            state_next = sts.tgts_zero ? S_ACK_CMP : S_ACK_CNT;
          end
          qbs_pkg::KIND_ACK: begin
            cmd.scan_start = 1'b1;
            state_next = sts.tiles_zero ? S_CALC : S_MIN_RD;
          end
          qbs_pkg::KIND_TARGET: begin
            cmd.store_target = 1'b1;
            cmd.scan_start = 1'b1;
            state_next = sts.tgts_zero ? S_ACK_CMP : S_ACK_CNT;
          end
          qbs_pkg::KIND_THREAD: begin
            cmd.store_thread = 1'b1;
            state_next = S_IDLE;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_BR_RD: state_next = S_BR_EV;
      S_BR_EV: begin
        cmd.br_eval = 1'b1;
        if (sts.last_tile) begin
          state_next = S_BR_END;
        end else begin
          cmd.scan_step = 1'b1;
          state_next = S_BR_RD;
        end
      end
      S_BR_END: begin
        if (!sts.br_hit) begin
          state_next = S_FLUSH;
        end else if (sts.push_ok) begin
          cmd.push = 1'b1;
          cmd.push_kind = qbs_pkg::MSG_ARRIVAL;
          cmd.push_dest = qbs_pkg::DEST_ZERO;
          state_next = S_FLUSH;
        end
      end
      S_ACK_CNT: begin
        cmd.run_eval = 1'b1;
        if (sts.last_tgt) begin
          state_next = S_ACK_CMP;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_ACK_CMP: begin
        if (sts.ack_equal) begin
          cmd.clear_count = 1'b1;
          cmd.scan_start = 1'b1;
          state_next = sts.tgts_zero ? S_FLUSH : S_ACK_EMIT;
        end else begin
          state_next = S_FLUSH;
        end
      end
      S_ACK_EMIT: begin
        if (!sts.tgt_hit || sts.push_ok) begin
          cmd.push = sts.tgt_hit;
          cmd.push_kind = qbs_pkg::MSG_ACK;
          cmd.push_dest = qbs_pkg::DEST_IDX;
          if (sts.last_tgt) begin
            state_next = S_FLUSH;
          end else begin
            cmd.scan_step = 1'b1;
          end
        end
      end
      S_MIN_RD: state_next = S_MIN_EV;
      S_MIN_EV: begin
        cmd.min_eval = 1'b1;
        if (sts.last_tile) begin
          state_next = S_CALC;
        end else begin
          cmd.scan_step = 1'b1;
          state_next = S_MIN_RD;
        end
      end
      S_CALC: begin
        if (sts.direct) begin
          cmd.nb_add = 1'b1;
          cmd.scan_start = 1'b1;
          state_next = sts.tiles_zero ? S_NOTE : S_REL_RD;
        end else begin
          cmd.div_start = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.nb_div = 1'b1;
          cmd.scan_start = 1'b1;
          state_next = sts.tiles_zero ? S_NOTE : S_REL_RD;
        end
      end
      S_REL_RD: state_next = S_REL_EV;
      S_REL_EV: begin
        if (!sts.rel_hit || sts.push_ok) begin
          cmd.push = sts.rel_hit;
          cmd.rel_clear = sts.rel_hit;
          cmd.push_kind = qbs_pkg::MSG_RELEASE;
          cmd.push_dest = qbs_pkg::DEST_IDX;
          if (sts.last_tile) begin
            state_next = S_NOTE;
          end else begin
            cmd.scan_step = 1'b1;
            state_next = S_REL_RD;
          end
        end
      end
      S_NOTE: begin
        if (sts.push_ok) begin
          cmd.push = 1'b1;
          cmd.push_kind = qbs_pkg::MSG_NOTIFY;
          cmd.push_dest = qbs_pkg::DEST_ZERO;
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (sts.push_ok) begin
          cmd.flush = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/quantum_barrier_sync.sv =====
// A wait below the barrier has its release queued at dispatch and sent when the item is
// flushed, after which the next transfer can follow. Other waits read and check each tile in
// use in turn. Arrivals and target updates step over each target in use to count running
// targets, and once more over each target when acknowledges go out. A global acknowledge
// searches the tiles for the minimum, runs the serial remainder unit when it is used, and
// makes a release pass over the tiles. A stalled consumer holds the block back. One item is
// processed at a time; results are held in a register while the consumer is not ready.
// Synchronous reset restores the register defaults, clears all tile state and the count.
module quantum_barrier_sync #(
  parameter int TILES     = 16,
  parameter int TARGETS   = 8,
  parameter int TIME_BITS = 48
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  qbs_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output qbs_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  qbs_pkg::cmd_t cmd;
  qbs_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  qbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  qbs_datapath #(
    .TILES     (TILES),
    .TARGETS   (TARGETS),
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// ===== verif/tb_quantum_barrier_sync.sv =====
module tb_quantum_barrier_sync;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  qbs_pkg::req_t req;
  logic rsp_valid;
  logic rsp_ready;
  qbs_pkg::rsp_t rsp;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

  quantum_barrier_sync i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the barrier server state.
  logic [31:0] sh_quantum;
  logic [4:0] sh_tiles;
  logic [3:0] sh_targets;
  logic [47:0] sh_clock [16];
  logic sh_waiting [16];
  logic sh_thread [16];
  logic sh_target_run [8];
  logic [3:0] sh_count;
  logic [47:0] sh_barrier;

  qbs_pkg::rsp_t pending_msgs [$];
  int errors;
  int sent_items;
  int checked_msgs;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_recv;

  initial begin
    clk = 1'b0;
  end
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int tiles_active();
    return (sh_tiles < 16) ? int'(sh_tiles) : 16;
  endfunction

  function automatic int targets_active();
    return (sh_targets < 8) ? int'(sh_targets) : 8;
  endfunction

  function automatic void queue_msg(logic [1:0] kind, logic [3:0] dest);
    qbs_pkg::rsp_t m;
    m.message_kind = kind;
    m.destination = dest;
    m.barrier_time = sh_barrier;
    m.last = 1'b0;
    pending_msgs.push_back(m);
  endfunction

  function automatic logic [47:0] sat_sum(logic [47:0] a, logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[48] ? TIME_MAX : s[47:0];
  endfunction

  function automatic void check_acks();
    int run_cnt;
    run_cnt = 0;
    for (int i = 0; i < targets_active(); i++) begin
      if (sh_target_run[i]) run_cnt++;
    end
    if (int'(sh_count) == run_cnt) begin
      for (int i = 0; i < targets_active(); i++) begin
        if (sh_target_run[i]) queue_msg(qbs_pkg::MSG_ACK, 4'(i));
      end
      sh_count = '0;
    end
  endfunction

  function automatic void predict_barrier(qbs_pkg::req_t it);
    int base;
    bit reached;
    bit blocked;
    bit any;
    logic [47:0] low;
    logic [47:0] d;
    base = pending_msgs.size();
    case (it.kind)
      qbs_pkg::KIND_WAIT: begin
        if (it.local_time < sh_barrier) begin
          queue_msg(qbs_pkg::MSG_RELEASE, it.tile_index);
        end else begin
          if (int'(it.tile_index) < tiles_active()) begin
            sh_clock[it.tile_index] = it.local_time;
            sh_waiting[it.tile_index] = 1'b1;
          end
          reached = 0;
          blocked = 0;
          for (int i = 0; i < tiles_active(); i++) begin
            if (sh_clock[i] < sh_barrier) begin
              if (sh_thread[i]) blocked = 1;
            end else begin
              reached = 1;
            end
          end
          if (reached && !blocked) queue_msg(qbs_pkg::MSG_ARRIVAL, 4'd0);
        end
      end
      qbs_pkg::KIND_ARRIVE: begin
        sh_count = sh_count + 4'd1;
        check_acks();
      end
      qbs_pkg::KIND_ACK: begin
        any = 0;
        low = '0;
        for (int i = 0; i < tiles_active(); i++) begin
          if (sh_waiting[i] && (!any || sh_clock[i] < low)) begin
            low = sh_clock[i];
            any = 1;
          end
        end
        if (!any || sh_barrier > low || sh_quantum == 0) begin
          sh_barrier = sat_sum(sh_barrier, sh_quantum);
        end else begin
          d = low - sh_barrier;
          sh_barrier = sat_sum(low - (d % {16'd0, sh_quantum}), sh_quantum);
        end
        for (int i = 0; i < tiles_active(); i++) begin
          if (sh_waiting[i] && sh_clock[i] < sh_barrier) begin
            queue_msg(qbs_pkg::MSG_RELEASE, 4'(i));
            sh_waiting[i] = 1'b0;
          end
        end
        queue_msg(qbs_pkg::MSG_NOTIFY, 4'd0);
      end
      qbs_pkg::KIND_TARGET: begin
        if (int'(it.target_index) < targets_active())
          sh_target_run[it.target_index] = it.status_bit;
        check_acks();
      end
      qbs_pkg::KIND_THREAD: begin
        sh_thread[it.tile_index] = it.status_bit;
      end
      default: begin
      end
    endcase
    if (pending_msgs.size() > base) pending_msgs[$].last = 1'b1;
  endfunction

  task automatic send_item(qbs_pkg::req_t it);
    @(posedge clk);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    req_valid <= 1'b1;
    req <= it;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predict_barrier(it);
    sent_items++;
    req_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    int guard;
    guard = 0;
    while (pending_msgs.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      qbs_pkg::REG_QUANTUM: begin
        sh_quantum = val;
        sh_barrier = {16'd0, val};
      end
      qbs_pkg::REG_TILES: sh_tiles = val[4:0];
      qbs_pkg::REG_TARGETS: sh_targets = val[3:0];
      default: begin
      end
    endcase
  endtask

  function automatic qbs_pkg::req_t make_item(logic [2:0] kind, logic [3:0] tile,
                                              logic [47:0] lt, logic [2:0] tgt, logic st);
    qbs_pkg::req_t it;
    it.kind = kind;
    it.tile_index = tile;
    it.local_time = lt;
    it.target_index = tgt;
    it.status_bit = st;
    return it;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (pending_msgs.size() == 0) begin
          $display("%0t unexpected result %h", $time, rsp);
          errors++;
        end else begin
          if (rsp !== pending_msgs[0]) begin
            $display("%0t mismatch expected %h actual %h", $time, pending_msgs[0], rsp);
            errors++;
          end
          void'(pending_msgs.pop_front());
          checked_msgs++;
        end
      end
      rsp_ready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic test_directed();
    send_item(make_item(qbs_pkg::KIND_WAIT, 4'd3, 48'd0, 3'd0, 1'b0));
    for (int i = 0; i < 4; i++)
      send_item(make_item(qbs_pkg::KIND_THREAD, 4'(i), '0, 3'd0, 1'b1));
    send_item(make_item(qbs_pkg::KIND_THREAD, 4'd15, '0, 3'd7, 1'b0));
    for (int i = 0; i < 4; i++)
      send_item(make_item(qbs_pkg::KIND_WAIT, 4'(i), 48'd1000 + 48'(i * 1500), 3'd0, 1'b0));
    for (int i = 0; i < 8; i++)
      send_item(make_item(qbs_pkg::KIND_ARRIVE, 4'd0, '0, 3'(i), 1'b0));
    send_item(make_item(qbs_pkg::KIND_ACK, 4'd0, '0, 3'd0, 1'b0));
    send_item(make_item(qbs_pkg::KIND_TARGET, 4'd0, '0, 3'd7, 1'b0));
    send_item(make_item(qbs_pkg::KIND_TARGET, 4'd0, '0, 3'd7, 1'b1));
    send_item(make_item(qbs_pkg::KIND_WAIT, 4'd15, TIME_MAX, 3'd0, 1'b1));
    send_item(make_item(3'd5, 4'd0, '0, 3'd0, 1'b0));
    send_item(make_item(3'd7, 4'hF, TIME_MAX, 3'd7, 1'b1));
    send_item(make_item(qbs_pkg::KIND_ACK, 4'd0, '0, 3'd0, 1'b0));
  endtask

  task automatic test_random(int count);
    qbs_pkg::req_t it;
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      it = make_item(qbs_pkg::KIND_WAIT, 4'($urandom_range(15)), '0, 3'($urandom_range(7)),
                     1'($urandom_range(1)));
      if (r < 40) begin
        it.local_time = sh_barrier + 48'($urandom_range(3000)) - 48'd500;
        if ($urandom_range(19) == 0) it.local_time = 48'({$urandom, $urandom});
      end else if (r < 60) begin
        it.kind = qbs_pkg::KIND_ARRIVE;
      end else if (r < 72) begin
        it.kind = qbs_pkg::KIND_ACK;
      end else if (r < 82) begin
        it.kind = qbs_pkg::KIND_TARGET;
      end else if (r < 95) begin
        it.kind = qbs_pkg::KIND_THREAD;
      end else begin
        it.kind = 3'($urandom_range(7));
        it.local_time = 48'({$urandom, $urandom});
      end
      send_item(it);
    end
  endtask

  task automatic test_config();
    write_reg(qbs_pkg::REG_QUANTUM, 32'd1);
    write_reg(qbs_pkg::REG_TILES, 32'd1);
    write_reg(qbs_pkg::REG_TARGETS, 32'd1);
    test_random(40);
    write_reg(qbs_pkg::REG_QUANTUM, 32'hFFFF_FFFF);
    write_reg(qbs_pkg::REG_TILES, 32'd16);
    write_reg(qbs_pkg::REG_TARGETS, 32'd8);
    test_random(30);
    write_reg(qbs_pkg::REG_QUANTUM, 32'd700);
    write_reg(qbs_pkg::REG_TILES, 32'd5);
    write_reg(qbs_pkg::REG_TARGETS, 32'd3);
    test_random(40);
    write_reg(qbs_pkg::REG_TILES, 32'd0);
    write_reg(qbs_pkg::REG_TARGETS, 32'd0);
    test_random(20);
    write_reg(qbs_pkg::REG_TILES, 32'd31);
    write_reg(qbs_pkg::REG_TARGETS, 32'd15);
    write_reg(qbs_pkg::REG_QUANTUM, 32'd1000);
  endtask

  task automatic test_idle_phases();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(80);
    send_idle_pct = 57; recv_stall_pct = 0;  test_random(70);
    send_idle_pct = 0;  recv_stall_pct = 57; test_random(70);
    send_idle_pct = 22; recv_stall_pct = 22; test_random(60);
    send_idle_pct = 0;  recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_recv = 1;
        repeat (400) @(posedge clk);
        hold_recv = 0;
      end
      test_random(30);
    join
    wait_drain();
    test_random(20);
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    sent_items = 0;
    checked_msgs = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_recv = 0;
    sh_quantum = 32'd1000;
    sh_tiles = 5'd16;
    sh_targets = 4'd8;
    sh_count = '0;
    sh_barrier = 48'd1000;
    for (int i = 0; i < 16; i++) begin
      sh_clock[i] = '0;
      sh_waiting[i] = 1'b0;
      sh_thread[i] = 1'b0;
    end
    for (int i = 0; i < 8; i++) sh_target_run[i] = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config();
    test_idle_phases();
    test_backpressure();
    wait_drain();
    if (pending_msgs.size() != 0) begin
      $display("%0t %0d expected results never arrived", $time, pending_msgs.size());
      errors++;
    end
    $display("Sent %0d requests and checked %0d messages across config and stall phases.",
             sent_items, checked_msgs);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
